[hw/rtl/ced_pkg.sv]
// shared types and constants for the chebyshev exp density block
// no dependencies; used by ced_mul, ced_div, the density unit and the bench
package ced_pkg;

    localparam int QW      = 49;
    localparam int MUL_W   = 48;
    localparam int PROD_W  = 96;
    localparam int DVD_W   = 32;
    localparam int DVS_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic signed [QW-1:0] q_t;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_TERMS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SQ   = 2'd2;

    localparam q_t SAT_Q16  = 49'sd70368744177663;
    localparam q_t ONE_Q16  = 49'sd65536;
    localparam q_t L_CLAMP  = 49'sd4194304;
    localparam q_t LOG2E_Q16 = 49'sd94548;
    localparam q_t LN2_Q30  = 49'sd744261118;
    localparam logic [31:0] ONE_Q30 = 32'd1073741824;
    localparam logic [PROD_W-1:0] MUL_LIM = 96'h3FFF_FFFF_FFFF_0000;

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } ced_mul_req_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } ced_div_req_t;

    function automatic q_t clamp_q(input q_t a);
        if (a > SAT_Q16)
            return SAT_Q16;
        else if (a < -SAT_Q16)
            return -SAT_Q16;
        else
            return a;
    endfunction

    function automatic logic clamp_hit(input q_t a);
        return (a > SAT_Q16) || (a < -SAT_Q16);
    endfunction

    // magnitude product back to signed q16, saturated
    function automatic q_t sat_prod(input logic [PROD_W-1:0] p, input logic neg);
        q_t m;
        m = (p > MUL_LIM) ? SAT_Q16 : $signed({1'b0, p[63:16]});
        return neg ? -m : m;
    endfunction

endpackage

[hw/rtl/ced_in_if.sv]
// input channel of the density block: valid/ready plus item payload
// depends on nothing
interface ced_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [3:0]  coef_index;
    logic signed [23:0] coef_value;
    logic [19:0] speed;

    modport source (output valid, operation, coef_index, coef_value, speed, input ready);
    modport sink   (input valid, operation, coef_index, coef_value, speed, output ready);
endinterface

[hw/rtl/ced_out_if.sv]
// result channel of the density block: valid/ready plus density and flag
// depends on nothing
interface ced_out_if;
    logic        valid;
    logic        ready;
    logic [47:0] density;
    logic        overflow;

    modport source (output valid, density, overflow, input ready);
    modport sink   (input valid, density, overflow, output ready);
endinterface

[hw/rtl/ced_mul.sv]
// shared unsigned multiplier, 48 x 48 bits in three 48 x 16 steps
// depends on ced_pkg
module ced_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ced_pkg::ced_mul_req_t         req,
    output logic                          done,
    output logic [ced_pkg::PROD_W-1:0]    prod
);
    logic [ced_pkg::MUL_W-1:0]  a_reg;
    logic [ced_pkg::MUL_W-1:0]  b_reg;
    logic [ced_pkg::PROD_W-1:0] acc_reg;
    logic [ced_pkg::PROD_W-1:0] acc_next;
    logic [1:0]                 cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [63:0]                part;

    // msb digit first, accumulator shifts up one digit a step
    assign part     = a_reg * b_reg[47:32];
    assign acc_next = {acc_reg[79:0], 16'd0} + {32'd0, part};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= '0;
            b_reg    <= '0;
            acc_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                a_reg    <= req.a;
                b_reg    <= req.b;
                acc_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                acc_reg <= acc_next;
                b_reg   <= {b_reg[31:0], 16'd0};
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd2)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule

[hw/rtl/ced_div.sv]
// shared restoring divider, 32 by 16 bits, one quotient bit a cycle
// depends on ced_pkg
module ced_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ced_pkg::ced_div_req_t      req,
    output logic                       done,
    output logic [ced_pkg::DVD_W-1:0]  quot
);
    localparam logic [4:0] LAST = 5'(ced_pkg::DVD_W - 1);

    logic [ced_pkg::DVS_W-1:0] rem_reg;
    logic [ced_pkg::DVS_W-1:0] dvs_reg;
    logic [ced_pkg::DVD_W-1:0] quo_reg;
    logic [4:0]                cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [ced_pkg::DVS_W:0]   trial;
    logic                      ge;
    logic [ced_pkg::DVS_W-1:0] rem_next;

    assign trial    = {rem_reg, quo_reg[ced_pkg::DVD_W-1]};
    assign ge       = trial >= {1'b0, dvs_reg};
    assign rem_next = ge ? ced_pkg::DVS_W'(trial - {1'b0, dvs_reg})
                         : trial[ced_pkg::DVS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            dvs_reg  <= '0;
            quo_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                rem_reg  <= '0;
                dvs_reg  <= req.divisor;
                quo_reg  <= req.dividend;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[ced_pkg::DVD_W-2:0], ge};
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
endmodule

[hw/rtl/chebyshev_exp_density_unit.sv]
// chebyshev exp density: sequencer, coefficient table and output register
// depends on ced_pkg, ced_in_if, ced_out_if, ced_mul, ced_div
//
// usage:
//   cmd carries items: operation 0 loads coef_value into table entry coef_index
//   (ignored past the table), operation 1 evaluates the density at speed.
//   result carries one density/overflow pair per evaluate, none per load.
//   an evaluate runs a sequencer over one shared 48x16-step multiplier and
//   one shared 32-step divider: one divide for x, up to two products per
//   term, two products for the exponent, then seven horner steps of two
//   products each, the division by the step number done as a product with
//   its reciprocal, and in weighted mode two products for the speed square.
//   cmd.ready is low while an evaluate is in flight.
//   the finished result sits in an output register; if the receiver stalls
//   the sequencer waits at the end until that register frees, while an
//   earlier result waits the block still takes the next item.
//   reset clears the control state and sets num_terms 11, speed_scale 1000,
//   weight_by_square 1; the coefficient table holds no value until loaded.
//   configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
//   and belong between items.
module chebyshev_exp_density_unit #(
    parameter int MAX_TERMS = 11
) (
    input  logic                             clk,
    input  logic                             rst_n,
    ced_in_if.sink                           cmd,
    ced_out_if.source                        result,
    input  logic                             cfg_we,
    input  logic [ced_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ced_pkg::CFG_DATA_W-1:0]   cfg_data
);
    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W = $clog2(MAX_TERMS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV_X, S_TERM, S_REC_WAIT, S_SUM_ISSUE, S_SUM_WAIT, S_L,
        S_Z_WAIT, S_U_WAIT, S_H_MUL, S_H_MWAIT, S_H_DIV, S_SQ_WAIT, S_P_WAIT,
        S_SCALE, S_DONE
    } state_t;

    state_t state_reg;

    logic [3:0]  num_terms_reg;
    logic [15:0] speed_scale_reg;
    logic        weight_sq_reg;

    logic [23:0] coef_mem [MAX_TERMS];

    logic [19:0]        s_reg;
    ced_pkg::q_t        x_reg;
    ced_pkg::q_t        tprev_reg;
    ced_pkg::q_t        tcur_reg;
    ced_pkg::q_t        term_reg;
    ced_pkg::q_t        sum_reg;
    logic [CNT_W-1:0]   i_reg;
    logic               neg_reg;
    logic               ov_reg;
    logic signed [9:0]  k_reg;
    logic [29:0]        u_reg;
    logic [31:0]        t_reg;
    logic [2:0]         hi_reg;
    logic [63:0]        p_reg;
    logic signed [10:0] e_reg;
    logic [47:0]        dens_reg;
    logic               out_valid_reg;
    logic [47:0]        out_dens_reg;
    logic               out_ov_reg;

    logic                  in_acc;
    logic [CNT_W-1:0]      n_terms;
    logic [23:0]           coef_rd;
    ced_pkg::q_t           coef_q;
    ced_pkg::q_t           op_a;
    ced_pkg::q_t           op_b;
    ced_pkg::q_t           mag_a;
    ced_pkg::q_t           mag_b;
    logic                  mul_go;
    ced_pkg::ced_mul_req_t mul_req;
    ced_pkg::ced_div_req_t div_req;
    logic                  mul_done;
    logic [ced_pkg::PROD_W-1:0] prod;
    logic                  div_done;
    logic [ced_pkg::DVD_W-1:0]  quot;
    ced_pkg::q_t           q_val;
    ced_pkg::q_t           rec_raw;
    ced_pkg::q_t           sum_raw;
    ced_pkg::q_t           l_neg;
    ced_pkg::q_t           l_cl;
    logic signed [41:0]    z_s;
    logic [41:0]           w;
    logic [15:0]           f_val;
    logic signed [9:0]     k_val;
    logic [47:0]           sc_dens;
    logic                  sc_sat;
    logic [5:0]            sh_amt;
    logic signed [10:0]    ne;
    logic [35:0]           recip;
    logic [31:0]           h_quot;

    assign in_acc  = cmd.valid && cmd.ready;
    assign n_terms = (num_terms_reg > 4'(MAX_TERMS)) ? CNT_W'(MAX_TERMS)
                                                    : CNT_W'(num_terms_reg);
    assign coef_rd = coef_mem[i_reg[IDX_W-1:0]];
    assign coef_q  = {{25{coef_rd[23]}}, coef_rd};

    always_ff @(posedge clk)
    begin
        if (in_acc && cmd.operation == ced_pkg::OP_LOAD && cmd.coef_index < 4'(MAX_TERMS))
            coef_mem[cmd.coef_index[IDX_W-1:0]] <= cmd.coef_value;
    end

    // signed product of the shared multiplier
    assign q_val   = ced_pkg::sat_prod(prod, neg_reg);
    assign rec_raw = (q_val <<< 1) - tprev_reg;
    assign sum_raw = sum_reg + q_val;
    assign l_neg   = -sum_reg;
    assign l_cl    = (l_neg > ced_pkg::L_CLAMP) ? ced_pkg::L_CLAMP :
                     (l_neg < -ced_pkg::L_CLAMP) ? -ced_pkg::L_CLAMP : l_neg;

    // z = L*log2e, then offset so that integer and fraction parts split cleanly
    assign z_s   = neg_reg ? -$signed({1'b0, prod[40:0]}) : $signed({1'b0, prod[40:0]});
    assign w     = 42'(z_s + 42'sd1099511627776);
    assign f_val = w[31:16];
    assign k_val = $signed({1'b0, w[40:32]}) - 10'sd256;

    // ceil(2^35 / n) for the horner step n, exact for 32-bit dividends
    always_comb
    begin
        case (hi_reg)
            3'd1:    recip = 36'h8_0000_0000;
            3'd2:    recip = 36'h4_0000_0000;
            3'd3:    recip = 36'h2_AAAA_AAAB;
            3'd4:    recip = 36'h2_0000_0000;
            3'd5:    recip = 36'h1_9999_999A;
            3'd6:    recip = 36'h1_5555_5556;
            3'd7:    recip = 36'h1_2492_4925;
            default: recip = 36'h8_0000_0000;
        endcase
    end

    assign h_quot = prod[66:35];

    always_comb
    begin
        mul_go = 1'b0;
        op_a   = '0;
        op_b   = '0;
        div_req = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && cmd.operation == ced_pkg::OP_EVAL)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {3'd0, cmd.speed, 9'd0};
                    div_req.divisor  = (speed_scale_reg == 16'd0) ? 16'd1 : speed_scale_reg;
                end
            end
            S_TERM:
            begin
                if (i_reg != n_terms && i_reg > CNT_W'(1))
                begin
                    mul_go = 1'b1;
                    op_a   = x_reg;
                    op_b   = tcur_reg;
                end
            end
            S_SUM_ISSUE:
            begin
                mul_go = 1'b1;
                op_a   = coef_q;
                op_b   = term_reg;
            end
            S_L:
            begin
                mul_go = 1'b1;
                op_a   = l_cl;
                op_b   = ced_pkg::LOG2E_Q16;
            end
            S_Z_WAIT:
            begin
                if (mul_done)
                begin
                    mul_go = 1'b1;
                    op_a   = {33'd0, f_val};
                    op_b   = ced_pkg::LN2_Q30;
                end
            end
            S_H_MUL:
            begin
                mul_go = 1'b1;
                op_a   = {19'd0, u_reg};
                op_b   = {17'd0, t_reg};
            end
            S_H_MWAIT:
            begin
                if (mul_done)
                begin
                    mul_go = 1'b1;
                    op_a   = {17'd0, prod[61:30]};
                    op_b   = {13'd0, recip};
                end
            end
            S_H_DIV:
            begin
                if (mul_done && hi_reg == 3'd1 && weight_sq_reg)
                begin
                    mul_go = 1'b1;
                    op_a   = {29'd0, s_reg};
                    op_b   = {29'd0, s_reg};
                end
            end
            S_SQ_WAIT:
            begin
                if (mul_done)
                begin
                    mul_go = 1'b1;
                    op_a   = {9'd0, prod[39:0]};
                    op_b   = {17'd0, t_reg >> 14};
                end
            end
            default:
            begin
                mul_go = 1'b0;
            end
        endcase
    end

    assign mag_a = op_a[ced_pkg::QW-1] ? -op_a : op_a;
    assign mag_b = op_b[ced_pkg::QW-1] ? -op_b : op_b;
    assign mul_req.start = mul_go;
    assign mul_req.a     = mag_a[ced_pkg::MUL_W-1:0];
    assign mul_req.b     = mag_b[ced_pkg::MUL_W-1:0];

    ced_mul u_mul (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (mul_req),
        .done (mul_done),
        .prod (prod)
    );

    ced_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .done (div_done),
        .quot (quot)
    );

    // final p * 2^e with saturation at 48 bits
    always_comb
    begin
        sc_dens = '0;
        sc_sat  = 1'b0;
        sh_amt  = '0;
        ne      = -e_reg;
        if (p_reg != 64'd0)
        begin
            if (!e_reg[10])
            begin
                if (e_reg >= 11'sd48)
                    sc_sat = 1'b1;
                else
                begin
                    sh_amt = 6'(11'sd48 - e_reg);
                    if ((p_reg >> sh_amt) != 64'd0)
                        sc_sat = 1'b1;
                    else
                        sc_dens = 48'(p_reg << e_reg[5:0]);
                end
                if (sc_sat)
                    sc_dens = '1;
            end
            else if (ne < 11'sd64)
                sc_dens = 48'(p_reg >> ne[5:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            num_terms_reg   <= 4'd11;
            speed_scale_reg <= 16'd1000;
            weight_sq_reg   <= 1'b1;
            s_reg           <= '0;
            x_reg           <= '0;
            tprev_reg       <= '0;
            tcur_reg        <= '0;
            term_reg        <= '0;
            sum_reg         <= '0;
            i_reg           <= '0;
            neg_reg         <= 1'b0;
            ov_reg          <= 1'b0;
            k_reg           <= '0;
            u_reg           <= '0;
            t_reg           <= '0;
            hi_reg          <= '0;
            p_reg           <= '0;
            e_reg           <= '0;
            dens_reg        <= '0;
            out_valid_reg   <= 1'b0;
            out_dens_reg    <= '0;
            out_ov_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ced_pkg::REG_NUM_TERMS:   num_terms_reg   <= cfg_data[3:0];
                    ced_pkg::REG_SPEED_SCALE: speed_scale_reg <= cfg_data;
                    ced_pkg::REG_WEIGHT_SQ:   weight_sq_reg   <= cfg_data[0];
                    default: ;
                endcase
            end

            if (mul_go)
                neg_reg <= op_a[ced_pkg::QW-1] ^ op_b[ced_pkg::QW-1];

            // in S_DONE the output register is reloaded below instead
            if (result.valid && result.ready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && cmd.operation == ced_pkg::OP_EVAL)
                    begin
                        s_reg     <= cmd.speed;
                        ov_reg    <= 1'b0;
                        state_reg <= S_DIV_X;
                    end
                end
                S_DIV_X:
                begin
                    if (div_done)
                    begin
                        x_reg     <= $signed({17'd0, quot}) - ced_pkg::ONE_Q16;
                        tcur_reg  <= $signed({17'd0, quot}) - ced_pkg::ONE_Q16;
                        tprev_reg <= ced_pkg::ONE_Q16;
                        sum_reg   <= '0;
                        i_reg     <= '0;
                        state_reg <= S_TERM;
                    end
                end
                S_TERM:
                begin
                    if (i_reg == n_terms)
                        state_reg <= S_L;
                    else if (i_reg == '0)
                    begin
                        term_reg  <= ced_pkg::ONE_Q16;
                        state_reg <= S_SUM_ISSUE;
                    end
                    else if (i_reg == CNT_W'(1))
                    begin
                        term_reg  <= x_reg;
                        state_reg <= S_SUM_ISSUE;
                    end
                    else
                        state_reg <= S_REC_WAIT;
                end
                S_REC_WAIT:
                begin
                    if (mul_done)
                    begin
                        tprev_reg <= tcur_reg;
                        tcur_reg  <= ced_pkg::clamp_q(rec_raw);
                        term_reg  <= ced_pkg::clamp_q(rec_raw);
                        if (prod > ced_pkg::MUL_LIM || ced_pkg::clamp_hit(rec_raw))
                            ov_reg <= 1'b1;
                        state_reg <= S_SUM_ISSUE;
                    end
                end
                S_SUM_ISSUE:
                begin
                    state_reg <= S_SUM_WAIT;
                end
                S_SUM_WAIT:
                begin
                    if (mul_done)
                    begin
                        sum_reg <= ced_pkg::clamp_q(sum_raw);
                        if (prod > ced_pkg::MUL_LIM || ced_pkg::clamp_hit(sum_raw))
                            ov_reg <= 1'b1;
                        i_reg     <= i_reg + CNT_W'(1);
                        state_reg <= S_TERM;
                    end
                end
                S_L:
                begin
                    state_reg <= S_Z_WAIT;
                end
                S_Z_WAIT:
                begin
                    if (mul_done)
                    begin
                        k_reg     <= k_val;
                        state_reg <= S_U_WAIT;
                    end
                end
                S_U_WAIT:
                begin
                    if (mul_done)
                    begin
                        u_reg     <= prod[45:16];
                        t_reg     <= ced_pkg::ONE_Q30;
                        hi_reg    <= 3'd7;
                        state_reg <= S_H_MUL;
                    end
                end
                S_H_MUL:
                begin
                    state_reg <= S_H_MWAIT;
                end
                S_H_MWAIT:
                begin
                    if (mul_done)
                        state_reg <= S_H_DIV;
                end
                S_H_DIV:
                begin
                    if (mul_done)
                    begin
                        t_reg <= ced_pkg::ONE_Q30 + h_quot;
                        if (hi_reg == 3'd1)
                        begin
                            if (weight_sq_reg)
                                state_reg <= S_SQ_WAIT;
                            else
                            begin
                                p_reg     <= {32'd0, ced_pkg::ONE_Q30 + h_quot};
                                e_reg     <= $signed({k_reg[9], k_reg}) - 11'sd14;
                                state_reg <= S_SCALE;
                            end
                        end
                        else
                        begin
                            hi_reg    <= hi_reg - 3'd1;
                            state_reg <= S_H_MUL;
                        end
                    end
                end
                S_SQ_WAIT:
                begin
                    if (mul_done)
                        state_reg <= S_P_WAIT;
                end
                S_P_WAIT:
                begin
                    if (mul_done)
                    begin
                        p_reg     <= prod[63:0];
                        e_reg     <= $signed({k_reg[9], k_reg}) - 11'sd16;
                        state_reg <= S_SCALE;
                    end
                end
                S_SCALE:
                begin
                    dens_reg <= sc_dens;
                    if (sc_sat)
                        ov_reg <= 1'b1;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    // wait for the output register to free before the transfer
                    if (!result.valid || result.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_dens_reg  <= dens_reg;
                        out_ov_reg    <= ov_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cmd.ready       = (state_reg == S_IDLE);
    assign result.valid    = out_valid_reg;
    assign result.density  = out_dens_reg;
    assign result.overflow = out_ov_reg;
endmodule

[test/chebyshev_exp_density_unit_tb.sv]
`timescale 1ns / 100ps
// self-checking bench for chebyshev_exp_density_unit: coefficient loads and density evals
// depends on ced_pkg, ced_in_if, ced_out_if and the rtl of the block
module chebyshev_exp_density_unit_tb;

    localparam int      TERMS_MAX  = 11;
    localparam longint  Q16_ONE    = 64'sd65536;
    localparam longint  Q16_SAT    = (64'sd1 <<< 46) - 1;
    localparam longint  EXP_CLAMP  = 64'sd64 <<< 16;
    localparam longint  LOG2E      = 64'sd94548;
    localparam longint unsigned LN2     = 64'd744261118;
    localparam longint unsigned Q30_ONE = 64'd1 << 30;
    localparam longint unsigned DMAX    = (64'd1 << 48) - 1;
    localparam int      DRAIN_CYCLES  = 450;
    localparam int      STALL_CYCLES  = 3000;
    localparam int      WATCHDOG_LIM  = 20000;

    typedef struct {
        logic        op;
        logic [3:0]  idx;
        logic [23:0] val;
        logic [19:0] spd;
        bit          typed;
        logic [47:0] dens;
        logic        ovf;
    } stim_row_t;

    typedef struct {
        logic [47:0] dens;
        logic        ovf;
    } density_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [ced_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ced_pkg::CFG_DATA_W-1:0] cfg_data;

    ced_in_if  cmd_ch();
    ced_out_if res_ch();

    chebyshev_exp_density_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    longint      coef_tab [TERMS_MAX];
    int unsigned terms_cfg;
    int unsigned scale_cfg;
    bit          weight_cfg;

    density_t  density_q [$];
    stim_row_t dir_rows [$];
    int        mismatches;
    int        idle_cycles;
    bit        hold_req;
    bit        no_idle;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint sat_q16(input longint a, inout bit ov);
        if (a > Q16_SAT)
        begin
            ov = 1'b1;
            return Q16_SAT;
        end
        if (a < -Q16_SAT)
        begin
            ov = 1'b1;
            return -Q16_SAT;
        end
        return a;
    endfunction

    function automatic longint mul_q16(input longint a, input longint b, inout bit ov);
        bit neg;
        longint unsigned ua, ub, lim, p;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        lim = longint'(Q16_SAT) << 16;
        if (ua != 0 && ub > lim / ua)
        begin
            ov = 1'b1;
            p = Q16_SAT;
        end
        else
        begin
            p = (ua * ub) >> 16;
            if (p > Q16_SAT)
            begin
                ov = 1'b1;
                p = Q16_SAT;
            end
        end
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint unsigned shift_out(input longint unsigned p, input int e,
                                                  inout bit ov);
        if (p == 0)
            return 0;
        if (e >= 0)
        begin
            if (e >= 48 || (p >> (48 - e)) != 0)
            begin
                ov = 1'b1;
                return DMAX;
            end
            return p << e;
        end
        if (-e >= 64)
            return 0;
        return p >> (-e);
    endfunction

    function automatic density_t predict_density(input logic [19:0] spd);
        density_t r;
        bit ov;
        longint unsigned s, sc, w, f, u, t, p, d;
        longint x, tprev, tcur, term, sum, lexp, z;
        int n, k;
        ov = 1'b0;
        s = spd;
        sc = (scale_cfg == 0) ? 1 : scale_cfg;
        x = longint'((s * 512) / sc) - Q16_ONE;
        n = (terms_cfg > TERMS_MAX) ? TERMS_MAX : terms_cfg;
        sum = 0;
        tprev = Q16_ONE;
        tcur = x;
        for (int i = 0; i < n; i++)
        begin
            if (i == 0)
                term = Q16_ONE;
            else if (i == 1)
                term = x;
            else
            begin
                term = sat_q16(2 * mul_q16(x, tcur, ov) - tprev, ov);
                tprev = tcur;
                tcur = term;
            end
            sum = sat_q16(sum + mul_q16(coef_tab[i], term, ov), ov);
        end
        lexp = -sum;
        if (lexp > EXP_CLAMP)
            lexp = EXP_CLAMP;
        if (lexp < -EXP_CLAMP)
            lexp = -EXP_CLAMP;
        z = lexp * LOG2E;
        w = z + (64'sd1 <<< 40);
        k = int'(w >> 32) - 256;
        f = (w >> 16) & 64'hFFFF;
        // exp of the fraction times ln2, horner in q30
        u = (f * LN2) >> 16;
        t = Q30_ONE;
        for (int i = 7; i >= 1; i--)
            t = Q30_ONE + ((u * t) >> 30) / i;
        if (weight_cfg)
        begin
            p = (t >> 14) * (s * s);
            d = shift_out(p, k - 16, ov);
        end
        else
            d = shift_out(t, k - 14, ov);
        r.dens = d[47:0];
        r.ovf = ov;
        return r;
    endfunction

    task automatic write_reg(input logic [ced_pkg::CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[ced_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == ced_pkg::REG_NUM_TERMS)
            terms_cfg = val & 32'hF;
        else if (idx == ced_pkg::REG_SPEED_SCALE)
            scale_cfg = val & 32'hFFFF;
        else if (idx == ced_pkg::REG_WEIGHT_SQ)
            weight_cfg = val[0];
    endtask

    // sender pause: everything drained and any load settled
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        while (density_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_item(input stim_row_t it);
        int gap, r;
        density_t e;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            gap = 0;
        else if (r < 93)
            gap = $urandom_range(1, 4);
        else
            gap = $urandom_range(10, 60);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.operation <= it.op;
        cmd_ch.coef_index <= it.idx;
        cmd_ch.coef_value <= it.val;
        cmd_ch.speed <= it.spd;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        if (it.op == ced_pkg::OP_LOAD)
        begin
            if (it.idx < TERMS_MAX)
                coef_tab[it.idx] = longint'($signed(it.val));
        end
        else
        begin
            e = predict_density(it.spd);
            if (it.typed)
            begin
                e.dens = it.dens;
                e.ovf = it.ovf;
            end
            density_q.push_back(e);
        end
    endtask

    function automatic stim_row_t rand_item();
        stim_row_t it;
        int unsigned top;
        it.typed = 1'b0;
        it.dens = '0;
        it.ovf = 1'b0;
        it.op = ($urandom_range(0, 99) < 45) ? ced_pkg::OP_EVAL : ced_pkg::OP_LOAD;
        it.idx = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(11, 15))
                                             : 4'($urandom_range(0, 10));
        if ($urandom_range(0, 9) < 4)
            it.val = 24'($urandom());
        else
            it.val = 24'($urandom_range(0, 1 << 18)) - 24'(1 << 17);
        // half the speeds keep x within [-1, 1]
        top = ((scale_cfg == 0 ? 1 : scale_cfg) * 256 > 20'hFFFFF) ? 20'hFFFFF
              : (scale_cfg == 0 ? 1 : scale_cfg) * 256;
        if ($urandom_range(0, 1))
            it.spd = 20'($urandom_range(0, top));
        else
            it.spd = 20'($urandom());
        return it;
    endfunction

    // result side: random ready with occasional long hold-off
    initial
    begin
        int r, len;
        res_ch.ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (hold_req)
            begin
                res_ch.ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            r = $urandom_range(0, 99);
            if (no_idle || r < 70)
            begin
                res_ch.ready <= 1'b1;
                len = $urandom_range(1, 10);
            end
            else
            begin
                res_ch.ready <= 1'b0;
                len = (r < 95) ? $urandom_range(1, 4) : $urandom_range(20, 80);
            end
            repeat (len) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        density_t e;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (density_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: density %0d overflow %0b",
                             res_ch.density, res_ch.overflow);
            end
            else
            begin
                e = density_q.pop_front();
                if (res_ch.density !== e.dens || res_ch.overflow !== e.ovf)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("density mismatch: expected %0d/%0b, got %0d/%0b",
                                 e.dens, e.ovf, res_ch.density, res_ch.overflow);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIM)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int phase_terms [9] = '{1, 11, 0, 15, 3, 6, 11, 12, 2};
        int phase_scale [9] = '{1, 65535, 0, 500, 2000, 250, 4095, 1000, 65534};
        int phase_wt    [9] = '{0, 1, 0, 1, 0, 1, 1, 0, 1};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.operation = ced_pkg::OP_LOAD;
        cmd_ch.coef_index = '0;
        cmd_ch.coef_value = '0;
        cmd_ch.speed = '0;
        mismatches = 0;
        idle_cycles = 0;
        hold_req = 1'b0;
        no_idle = 1'b0;
        terms_cfg = 11;
        scale_cfg = 1000;
        weight_cfg = 1'b1;
        foreach (coef_tab[i])
            coef_tab[i] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero table: density is speed squared in weighted mode
        for (int i = 0; i < TERMS_MAX; i++)
            dir_rows.push_back('{ced_pkg::OP_LOAD, 4'(i), 24'h0, 20'h0, 1'b0, 48'h0, 1'b0});
        // index past the table is ignored
        dir_rows.push_back('{ced_pkg::OP_LOAD, 4'hF, 24'h7FFFFF, 20'h0, 1'b0, 48'h0, 1'b0});
        dir_rows.push_back('{ced_pkg::OP_EVAL, 4'h0, 24'h0, 20'h0, 1'b1, 48'h0, 1'b0});
        // top speed: the high-order terms saturate even with zero coefficients
        dir_rows.push_back('{ced_pkg::OP_EVAL, 4'h0, 24'h0, 20'hFFFFF, 1'b1,
                             48'd1099509530625, 1'b1});
        dir_rows.push_back('{ced_pkg::OP_EVAL, 4'h0, 24'h0, 20'd256, 1'b1, 48'd65536, 1'b0});
        dir_rows.push_back('{ced_pkg::OP_LOAD, 4'h0, 24'h7FFFFF, 20'h0, 1'b0, 48'h0, 1'b0});
        dir_rows.push_back('{ced_pkg::OP_EVAL, 4'h0, 24'h0, 20'd128000, 1'b0, 48'h0, 1'b0});
        // most negative c0 drives the exponential to saturation
        dir_rows.push_back('{ced_pkg::OP_LOAD, 4'h0, 24'h800000, 20'h0, 1'b0, 48'h0, 1'b0});
        dir_rows.push_back('{ced_pkg::OP_EVAL, 4'h0, 24'h0, 20'hFFFFF, 1'b1,
                             48'hFFFF_FFFF_FFFF, 1'b1});
        dir_rows.push_back('{ced_pkg::OP_EVAL, 4'h0, 24'h0, 20'h0, 1'b1, 48'h0, 1'b0});
        dir_rows.push_back('{ced_pkg::OP_LOAD, 4'hA, 24'h800000, 20'h0, 1'b0, 48'h0, 1'b0});
        dir_rows.push_back('{ced_pkg::OP_LOAD, 4'h5, 24'h7FFFFF, 20'h0, 1'b0, 48'h0, 1'b0});
        dir_rows.push_back('{ced_pkg::OP_EVAL, 4'h0, 24'h0, 20'hFFFFF, 1'b0, 48'h0, 1'b0});
        foreach (dir_rows[i])
            send_item(dir_rows[i]);

        for (int ph = 0; ph < 9; ph++)
        begin
            wait_drained();
            write_reg(ced_pkg::REG_NUM_TERMS, phase_terms[ph]);
            write_reg(ced_pkg::REG_SPEED_SCALE, phase_scale[ph]);
            write_reg(ced_pkg::REG_WEIGHT_SQ, phase_wt[ph]);
            no_idle = (ph == 4);
            if (ph == 2 || ph == 6)
                hold_req = 1'b1;
            repeat (125)
                send_item(rand_item());
        end
        cmd_ch.valid <= 1'b0;

        while (density_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
